// ----- hdl/nsd_pkg.sv -----
// Shared constants, codes and control/status types for the note start delay block.
`default_nettype none
package nsd_pkg;

  localparam int BLOCK_SAMPLES      = 16;
  localparam int BEAT_FRACTION_BITS = 16;
  localparam int SEEK_TOLERANCE     = 66;
  localparam int SEC_FRAC_BITS      = 16;

  localparam int SR_W     = 18;                 // sample rate
  localparam int DELAY_W  = 24;                 // seconds, Q8.16
  localparam int BEAT_W   = 32;                 // song position
  localparam int BAR_W    = 24;                 // bar length / sync offset
  localparam int TRIG_W   = 34;                 // trigger beat
  localparam int AGE_W    = 32;                 // sample age
  localparam int DSUM_W   = DELAY_W + 1;
  localparam int PROD_W   = DSUM_W + SR_W;
  localparam int THR_W    = PROD_W + 1 - SEC_FRAC_BITS;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 8;
  localparam int DIV_STEPS  = BEAT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // in_tuser codes
  localparam logic CMD_ARM  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE = 2'd0,
    CFG_LAYER_DELAY = 2'd1,
    CFG_TRIG_OFFSET = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARM_MUL,
    ST_ARM_SET,
    ST_CHECK,
    ST_DIV,
    ST_TRIG,
    ST_EVAL,
    ST_AGE,
    ST_DONE
  } nsd_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic arm_mul;
    logic arm_set;
    logic div_start;
    logic trig_set;
    logic set_wait;
    logic sync_clear;
    logic age_update;
    logic out_load;
  } nsd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic armed;
    logic sync_active;
    logic need_recalc;
    logic before_trig;
    logic div_done;
  } nsd_sts_t;

endpackage
`default_nettype wire

// ----- hdl/nsd_div.sv -----
// Bit-serial remainder unit: song position modulo bar length, one bit per cycle.
`default_nettype none
module nsd_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [nsd_pkg::BEAT_W-1:0]    dividend,
  input  wire [nsd_pkg::BAR_W-1:0]     divisor,
  output logic [nsd_pkg::BAR_W-1:0]    remainder,
  output logic                         done
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [nsd_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [nsd_pkg::BAR_W-1:0]     rem_r, rem_nxt;
  logic [nsd_pkg::BEAT_W-1:0]    dvd_r, dvd_nxt;
  logic [nsd_pkg::BAR_W:0]       shifted;
  logic                          ge;

  assign shifted = {rem_r, dvd_r[nsd_pkg::BEAT_W-1]};
  assign ge      = shifted >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      // restoring step: shift in the next dividend bit, subtract if it fits
      rem_nxt = ge ? nsd_pkg::BAR_W'(shifted - {1'b0, divisor})
                   : shifted[nsd_pkg::BAR_W-1:0];
      dvd_nxt = {dvd_r[nsd_pkg::BEAT_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == nsd_pkg::DIV_CNT_W'(nsd_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign remainder = rem_r;
  assign done      = done_r;

endmodule
`default_nettype wire

// ----- hdl/nsd_dp.sv -----
// Datapath: registers, threshold multiply, trigger math, age counter and result register.
`default_nettype none
module nsd_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire nsd_pkg::nsd_cmd_t           cmd,
  output nsd_pkg::nsd_sts_t                sts,
  input  wire                              cfg_we,
  input  wire [nsd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire [nsd_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire [nsd_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic [nsd_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // configuration
  logic [nsd_pkg::SR_W-1:0]    sample_rate_r;
  logic [nsd_pkg::DELAY_W-1:0] layer_delay_r;
  logic [nsd_pkg::BAR_W-1:0]   trig_ofs_r;

  // latched item
  logic [nsd_pkg::BAR_W-1:0]   bar_in_r;
  logic [nsd_pkg::DELAY_W-1:0] extra_r;
  logic [nsd_pkg::BEAT_W-1:0]  cur_r;

  // pending note state
  logic                        armed_r, sync_active_r, recalc_pending_r;
  logic [nsd_pkg::BAR_W-1:0]   bar_length_r;
  logic [nsd_pkg::BEAT_W-1:0]  reference_beat_r;
  logic [nsd_pkg::TRIG_W-1:0]  trigger_beat_r;
  logic [nsd_pkg::AGE_W-1:0]   age_samples_r;
  logic [nsd_pkg::THR_W-1:0]   threshold_r;
  logic [nsd_pkg::PROD_W-1:0]  prod_r;

  // result of the current item
  logic                        res_fire_r, res_wait_r;
  logic                        o_fire_r, o_wait_r;

  logic [nsd_pkg::DSUM_W-1:0]  dsum;
  logic [nsd_pkg::PROD_W-1:0]  prod_c;
  logic [nsd_pkg::PROD_W:0]    thr_sum;
  logic [nsd_pkg::THR_W-1:0]   thr_c;
  logic                        bar_nz;
  logic                        seek_back, past_trig, backward, next_bar;
  logic [nsd_pkg::BAR_W-1:0]   rel;
  logic [nsd_pkg::BEAT_W-1:0]  bar_base;
  logic [nsd_pkg::TRIG_W-1:0]  trig_c;
  logic [nsd_pkg::AGE_W:0]     age_sum;
  logic [nsd_pkg::AGE_W-1:0]   age_c;
  logic                        div_done;

  assign dsum    = {1'b0, layer_delay_r} + {1'b0, extra_r};
  assign prod_c  = dsum * sample_rate_r;
  // round up to whole samples; the product never reaches the age limit
  assign thr_sum = {1'b0, prod_r} + (nsd_pkg::PROD_W + 1)'((1 << nsd_pkg::SEC_FRAC_BITS) - 1);
  assign thr_c   = thr_sum[nsd_pkg::PROD_W:nsd_pkg::SEC_FRAC_BITS];
  assign bar_nz  = bar_in_r != '0;

  assign seek_back = ({1'b0, cur_r} + (nsd_pkg::BEAT_W + 1)'(nsd_pkg::SEEK_TOLERANCE))
                     < {1'b0, reference_beat_r};
  assign past_trig = {3'b000, cur_r}
                     >= ({1'b0, trigger_beat_r}
                         + (nsd_pkg::TRIG_W + 1)'(1 << nsd_pkg::BEAT_FRACTION_BITS));

  nsd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (cur_r),
    .divisor   (bar_length_r),
    .remainder (rel),
    .done      (div_done)
  );

  assign backward  = !recalc_pending_r && (cur_r < reference_beat_r);
  assign next_bar  = !backward && (trig_ofs_r <= rel);
  assign bar_base  = cur_r - nsd_pkg::BEAT_W'(rel);
  assign trig_c    = nsd_pkg::TRIG_W'(bar_base)
                   + (next_bar ? nsd_pkg::TRIG_W'(bar_length_r) : '0)
                   + nsd_pkg::TRIG_W'(trig_ofs_r);

  // saturate the age at its top value
  assign age_sum = {1'b0, age_samples_r} + (nsd_pkg::AGE_W + 1)'(nsd_pkg::BLOCK_SAMPLES);
  assign age_c   = age_sum[nsd_pkg::AGE_W] ? '1 : age_sum[nsd_pkg::AGE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= nsd_pkg::SR_W'(44100);
      layer_delay_r <= '0;
      trig_ofs_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        nsd_pkg::CFG_SAMPLE_RATE: sample_rate_r <= cfg_wdata[nsd_pkg::SR_W-1:0];
        nsd_pkg::CFG_LAYER_DELAY: layer_delay_r <= cfg_wdata[nsd_pkg::DELAY_W-1:0];
        nsd_pkg::CFG_TRIG_OFFSET: trig_ofs_r    <= cfg_wdata[nsd_pkg::BAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r          <= 1'b0;
      sync_active_r    <= 1'b0;
      recalc_pending_r <= 1'b0;
    end else begin
      if (cmd.arm_set) begin
        armed_r          <= 1'b1;
        sync_active_r    <= bar_nz;
        recalc_pending_r <= bar_nz;
      end
      if (cmd.trig_set)
        recalc_pending_r <= 1'b0;
      if (cmd.sync_clear)
        sync_active_r <= 1'b0;
      if (cmd.age_update && (age_c >= nsd_pkg::AGE_W'(threshold_r)))
        armed_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bar_in_r   <= in_tdata[23:0];
      extra_r    <= in_tdata[47:24];
      cur_r      <= in_tdata[79:48];
      res_fire_r <= 1'b0;
      res_wait_r <= 1'b0;
    end
    if (cmd.arm_mul)
      prod_r <= prod_c;
    if (cmd.arm_set) begin
      bar_length_r     <= bar_in_r;
      reference_beat_r <= '0;
      trigger_beat_r   <= '0;
      age_samples_r    <= '0;
      threshold_r      <= thr_c;
      res_wait_r       <= bar_nz;
    end
    if (cmd.trig_set) begin
      reference_beat_r <= cur_r;
      trigger_beat_r   <= trig_c;
    end
    if (cmd.set_wait)
      res_wait_r <= 1'b1;
    if (cmd.age_update) begin
      age_samples_r <= age_c;
      if (age_c >= nsd_pkg::AGE_W'(threshold_r))
        res_fire_r <= 1'b1;
    end
    if (cmd.out_load) begin
      o_fire_r <= res_fire_r;
      o_wait_r <= res_wait_r;
    end
  end

  assign sts.armed       = armed_r;
  assign sts.sync_active = sync_active_r;
  assign sts.need_recalc = recalc_pending_r || seek_back || past_trig;
  assign sts.before_trig = {2'b00, cur_r} < trigger_beat_r;
  assign sts.div_done    = div_done;

  assign out_tdata = {6'b000000, o_wait_r, o_fire_r};

endmodule
`default_nettype wire

// ----- hdl/nsd_ctrl.sv -----
// Controller: sequences arm and tick items and owns the output handshake.
`default_nettype none
module nsd_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire                  in_tuser,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  input  wire nsd_pkg::nsd_sts_t sts,
  output nsd_pkg::nsd_cmd_t    cmd
);

  nsd_pkg::nsd_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept, out_free;

  assign accept   = in_tvalid && (state_r == nsd_pkg::ST_IDLE);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nsd_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (in_tuser == nsd_pkg::CMD_ARM) state_nxt = nsd_pkg::ST_ARM_MUL;
          else if (!sts.armed)          state_nxt = nsd_pkg::ST_DONE;
          else if (sts.sync_active)     state_nxt = nsd_pkg::ST_CHECK;
          else                          state_nxt = nsd_pkg::ST_AGE;
        end
      end
      nsd_pkg::ST_ARM_MUL: state_nxt = nsd_pkg::ST_ARM_SET;
      nsd_pkg::ST_ARM_SET: state_nxt = nsd_pkg::ST_DONE;
      nsd_pkg::ST_CHECK:
        state_nxt = sts.need_recalc ? nsd_pkg::ST_DIV : nsd_pkg::ST_EVAL;
      nsd_pkg::ST_DIV:
        if (sts.div_done) state_nxt = nsd_pkg::ST_TRIG;
      nsd_pkg::ST_TRIG: state_nxt = nsd_pkg::ST_EVAL;
      nsd_pkg::ST_EVAL:
        state_nxt = sts.before_trig ? nsd_pkg::ST_DONE : nsd_pkg::ST_AGE;
      nsd_pkg::ST_AGE:  state_nxt = nsd_pkg::ST_DONE;
      nsd_pkg::ST_DONE:
        if (out_free) state_nxt = nsd_pkg::ST_IDLE;
      default: state_nxt = nsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      nsd_pkg::ST_IDLE:    cmd.load_in   = accept;
      nsd_pkg::ST_ARM_MUL: cmd.arm_mul   = 1'b1;
      nsd_pkg::ST_ARM_SET: cmd.arm_set   = 1'b1;
      nsd_pkg::ST_CHECK:   cmd.div_start = sts.need_recalc;
      nsd_pkg::ST_DIV:     ;
      nsd_pkg::ST_TRIG:    cmd.trig_set  = 1'b1;
      nsd_pkg::ST_EVAL: begin
        cmd.set_wait   = sts.before_trig;
        cmd.sync_clear = !sts.before_trig;
      end
      nsd_pkg::ST_AGE:     cmd.age_update = 1'b1;
      nsd_pkg::ST_DONE:    cmd.out_load   = out_free;
      default: ;
    endcase
  end

  // hold the result until taken; a new one may replace it in the same cycle
  always_comb begin
    priority if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready)       out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == nsd_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ----- hdl/note_start_delay_beat_sync_top.sv -----
// Top level of the note start delay block with beat sync.
//
//  channel  direction  tuser        tdata (lowest bit first)
//  in_      slave      cmd (0 arm)  sync_bar_beats[23:0], extra_delay[47:24],
//                                   current_beat[79:48]
//  out_     master     -            fire[0], waiting_for_beat[1], zero[7:2]
//  cfg_     write      -            idx 0 sample_rate, 1 layer_delay, 2 trigger offset
//
// An arm item steps through accept, threshold multiply, state load and result.
// A tick that recomputes the trigger waits on the 32-step bit-serial remainder
// unit; other ticks do without it.
// One item is in work at a time; the next is taken while the result still waits.
// A stalled output holds the block in its result state. Reset is synchronous,
// active low, and needs no clearing pass.
`default_nettype none
module note_start_delay_beat_sync_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [nsd_pkg::IN_DATA_W-1:0]     in_tdata,   // sync_bar_beats, extra_delay, current_beat
  input  wire                              in_tuser,   // cmd
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [nsd_pkg::OUT_DATA_W-1:0]   out_tdata,  // fire, waiting_for_beat, zero fill
  input  wire                              cfg_we,
  input  wire [nsd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire [nsd_pkg::CFG_W-1:0]         cfg_wdata
);

  nsd_pkg::nsd_cmd_t cmd;
  nsd_pkg::nsd_sts_t sts;

  nsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  nsd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire

// ----- hdl/nsd_chk.sv -----
// Port-level checker for the note start delay block, bound to the top level.
`default_nettype none
module nsd_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [nsd_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  // a note cannot fire while still waiting for its beat
  a_fire_excl_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("fire and waiting_for_beat both set");

  // a fresh result never shows in the cycle right after an accept
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result appeared too early");

endmodule

bind note_start_delay_beat_sync_top nsd_chk u_nsd_chk (.*);
`default_nettype wire

// ----- bench/tb_note_start_delay_beat_sync_top.sv -----
// Self-checking testbench for the note start delay block with beat sync.
module tb_note_start_delay_beat_sync_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [33:0] ONE_BEAT = 34'd1 << nsd_pkg::BEAT_FRACTION_BITS;
  localparam logic [43:0] ROUND_UP = (44'd1 << nsd_pkg::SEC_FRAC_BITS) - 44'd1;
  localparam int IDLE_SETTLE  = 40;
  localparam int STALL_CYCLES = 300;

  typedef struct packed {
    logic fire;
    logic waiting;
  } note_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [nsd_pkg::IN_DATA_W-1:0]  in_tdata;   // sync_bar_beats, extra_delay, current_beat
  logic                           in_tuser;   // cmd
  logic                           out_tvalid;
  logic                           out_tready;
  logic [nsd_pkg::OUT_DATA_W-1:0] out_tdata;  // fire, waiting_for_beat, zero fill
  logic                           cfg_we;
  logic [nsd_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [nsd_pkg::CFG_W-1:0]      cfg_wdata;

  // register copies
  logic [17:0] rate_cfg;
  logic [23:0] layer_cfg;
  logic [23:0] offset_cfg;

  // pending note state
  logic        note_armed;
  logic        sync_on;
  logic [23:0] bar_len;
  logic        recalc_due;
  logic [31:0] ref_beat;
  logic [33:0] trig_beat;
  logic [31:0] note_age;
  logic [31:0] fire_at;

  note_result_t due_results[$];
  int unsigned  fail_count;
  int unsigned  items_sent;
  bit           steady;
  bit           hold_req;

  note_start_delay_beat_sync_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic note_result_t advance_note(input logic is_tick, input logic [23:0] bar_in,
                                                input logic [23:0] extra, input logic [31:0] beat);
    note_result_t r;
    logic [24:0]  delay_sum;
    logic [42:0]  prod;
    logic [43:0]  rounded;
    logic [33:0]  pos;
    logic [31:0]  rel;
    logic [33:0]  bar_base;
    logic [32:0]  next_age;
    logic         seek_back;
    logic         backward;
    logic         held;
    r = '0;
    pos = {2'b00, beat};
    if (is_tick == nsd_pkg::CMD_ARM) begin
      // threshold is frozen here from the registers in force
      delay_sum = layer_cfg + extra;
      prod = delay_sum * rate_cfg;
      rounded = prod + ROUND_UP;
      fire_at = 32'(rounded >> nsd_pkg::SEC_FRAC_BITS);
      note_armed = 1'b1;
      sync_on = (bar_in != '0);
      bar_len = bar_in;
      recalc_due = sync_on;
      ref_beat = '0;
      trig_beat = '0;
      note_age = '0;
      r.waiting = sync_on;
    end else if (note_armed) begin
      held = 1'b0;
      if (sync_on) begin
        seek_back = (pos + nsd_pkg::SEEK_TOLERANCE) < {2'b00, ref_beat};
        if (recalc_due || seek_back || pos >= trig_beat + ONE_BEAT) begin
          // a backward seek always lands in the current bar
          backward = !recalc_due && (beat < ref_beat);
          ref_beat = beat;
          rel = beat % {8'h00, bar_len};
          bar_base = pos - rel;
          if (!backward && {8'h00, offset_cfg} <= rel) begin
            trig_beat = bar_base + bar_len + offset_cfg;
          end else begin
            trig_beat = bar_base + offset_cfg;
          end
          recalc_due = 1'b0;
        end
        if (pos < trig_beat) begin
          r.waiting = 1'b1;
          held = 1'b1;
        end else begin
          sync_on = 1'b0;
        end
      end
      if (!held) begin
        next_age = note_age + nsd_pkg::BLOCK_SAMPLES;
        note_age = next_age[32] ? '1 : next_age[31:0];
        if (note_age >= fire_at) begin
          r.fire = 1'b1;
          note_armed = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    note_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("result with none expected: fire=%0b waiting_for_beat=%0b",
               out_tdata[0], out_tdata[1]);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (out_tdata[0] !== want.fire) begin
          $error("fire: expected %0b, got %0b", want.fire, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[1] !== want.waiting) begin
          $error("waiting_for_beat: expected %0b, got %0b", want.waiting, out_tdata[1]);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned n;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        for (n = 0; n < STALL_CYCLES; n++) @(posedge clk);
      end
      out_tready <= steady || ($urandom_range(99) >= 33);
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("[note_start_delay_beat_sync_top] ERROR");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [23:0] bar_in,
                           input logic [23:0] extra, input logic [31:0] beat);
    while (!steady && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {beat, extra, bar_in};
    do @(posedge clk); while (!in_tready);
    due_results.push_back(advance_note(cmd, bar_in, extra, beat));
    items_sent++;
  endtask

  task automatic send_arm(input logic [23:0] bar_in, input logic [23:0] extra);
    send_item(nsd_pkg::CMD_ARM, bar_in, extra, $urandom);
  endtask

  task automatic send_tick(input logic [31:0] beat);
    send_item(nsd_pkg::CMD_TICK, 24'($urandom), 24'($urandom), beat);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input nsd_pkg::cfg_idx_t idx, input logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      nsd_pkg::CFG_SAMPLE_RATE: rate_cfg = value[17:0];
      nsd_pkg::CFG_LAYER_DELAY: layer_cfg = value;
      nsd_pkg::CFG_TRIG_OFFSET: offset_cfg = value;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [23:0] rate, input logic [23:0] layer,
                            input logic [23:0] offset);
    wait_idle();
    write_reg(nsd_pkg::CFG_SAMPLE_RATE, rate);
    write_reg(nsd_pkg::CFG_LAYER_DELAY, layer);
    write_reg(nsd_pkg::CFG_TRIG_OFFSET, offset);
  endtask

  // largest extra delay that still fires within about a dozen ticks
  function automatic int unsigned delay_budget();
    return (32'(nsd_pkg::BLOCK_SAMPLES) * 12 << nsd_pkg::SEC_FRAC_BITS) / rate_cfg;
  endfunction

  // one arm followed by a wandering song position until the note fires
  task automatic play_note();
    logic [23:0] bar_in;
    logic [23:0] extra;
    logic [31:0] pos;
    int unsigned span;
    int unsigned ticks;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      // throwaway note with wide fields, replaced by the arm below
      send_arm(24'($urandom), 24'($urandom));
      repeat ($urandom_range(3)) send_tick($urandom);
    end
    roll = $urandom_range(99);
    if (roll < 20) bar_in = '0;
    else if (roll < 90) bar_in = 24'($urandom_range(32'h80000, 32'h100));
    else bar_in = 24'($urandom);
    extra = 24'($urandom_range(delay_budget()));
    send_arm(bar_in, extra);
    span = ((bar_in > offset_cfg) ? bar_in : offset_cfg) / 4 + 1;
    if ($urandom_range(9) == 0) pos = 32'hFFFF_FFFF - 32'($urandom_range(span * 8));
    else pos = $urandom;
    ticks = 0;
    while (note_armed && ticks < 64) begin
      send_tick(pos);
      ticks++;
      roll = $urandom_range(99);
      if (roll < 8) pos = pos - 32'($urandom_range(span * 2, 67));
      else if (roll < 14) pos = pos - 32'($urandom_range(80));
      else if (roll < 18) pos = pos + 32'(span * 8 + $urandom_range(span));
      else if (roll < 20) pos = $urandom;
      else pos = pos + 32'($urandom_range(span));
    end
    if ($urandom_range(4) == 0) repeat ($urandom_range(2, 1)) send_tick(pos);
  endtask

  task automatic test_unarmed_and_zero_delay();
    send_tick(32'h0000_0000);
    send_tick(32'hFFFF_FFFF);
    send_arm(24'h000000, 24'h000000);
    send_tick($urandom);
    send_tick($urandom);
  endtask

  task automatic test_delay_extremes();
    set_config(24'd192000, 24'hFFFFFF, 24'h000000);
    send_arm(24'h000000, 24'hFFFFFF);
    send_tick($urandom);
    send_tick($urandom);
    // arm while armed: the old note is dropped
    send_arm(24'h000000, 24'h000000);
    send_tick($urandom);
    set_config(24'd8000, 24'h000000, 24'hFFFFFF);
    send_arm(24'h000000, 24'h000001);
    send_tick($urandom);
    send_tick($urandom);
  endtask

  task automatic test_beat_sync();
    // offset beyond the bar, trigger past the 32-bit position range
    send_arm(24'h010000, 24'h000000);
    send_tick(32'h0000_0000);
    send_tick(32'h00FF_FFFE);
    send_tick(32'h00FF_FFFF);
    send_arm(24'hFFFFFF, 24'h000000);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h0000_0000);
    send_tick(32'h00FF_FFFF);
    set_config(24'd44100, 24'h000000, 24'h008000);
    // small jitter back is tolerated, one step more is a seek
    send_arm(24'h040000, 24'd3);
    send_tick(32'h0001_0000);
    send_tick(32'h0001_0000 - nsd_pkg::SEEK_TOLERANCE);
    send_tick(32'h0001_0000 - nsd_pkg::SEEK_TOLERANCE - 1);
    // a beat past the trigger forces a new trigger in the next bar
    send_arm(24'h040000, 24'h000000);
    send_tick(32'h0000_0100);
    send_tick(32'h0001_8000);
    send_tick(32'h0004_8000);
  endtask

  task automatic test_output_stall();
    int unsigned stop_at;
    wait_idle();
    steady = 1'b1;
    hold_req = 1'b1;
    stop_at = items_sent + 40;
    while (items_sent < stop_at) play_note();
    steady = 1'b0;
    wait_idle();
    // hold the sender until every result is back, then go on
    repeat (3) play_note();
    wait_idle();
    repeat (3) play_note();
  endtask

  task automatic test_random_notes();
    int unsigned stop_at;
    int unsigned phase;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(24'd44100, 24'd0, 24'h000000);
        1: set_config(24'd8000, 24'd700, 24'h008000);
        2: set_config(24'd192000, 24'd0, 24'($urandom_range(32'hFFFF)));
        3: set_config(24'($urandom_range(192000, 8000)), 24'($urandom_range(20)),
                      24'($urandom_range(32'h20000)));
        default: set_config(24'd48000, 24'd40, 24'h010000);
      endcase
      steady = (phase == 0);
      stop_at = items_sent + 230;
      while (items_sent < stop_at) play_note();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = nsd_pkg::CMD_ARM;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_idx    = nsd_pkg::CFG_SAMPLE_RATE;
    cfg_wdata  = '0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    fail_count = 0;
    items_sent = 0;
    rate_cfg   = 18'd44100;
    layer_cfg  = '0;
    offset_cfg = '0;
    note_armed = 1'b0;
    sync_on    = 1'b0;
    bar_len    = '0;
    recalc_due = 1'b0;
    ref_beat   = '0;
    trig_beat  = '0;
    note_age   = '0;
    fire_at    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unarmed_and_zero_delay();
    test_delay_extremes();
    test_beat_sync();
    test_output_stall();
    test_random_notes();

    wait_idle();
    if (fail_count == 0) begin
      $display("[note_start_delay_beat_sync_top] OK");
    end else begin
      $display("[note_start_delay_beat_sync_top] ERROR");
    end
    $finish;
  end

endmodule
